/* sv/pds_pkg.sv */
// ----------------------------------------------------------------------------
// Palette downscale package
// Shared types and constants of the palette downscaling pixel stream.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int COLOR_W = 16;
	localparam int BYTE_W  = 8;

	// Depth of the queue between the front and the back, and its count width.
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	// Register reset values.
	localparam logic [8:0] OUT_WIDTH_RESET  = 9'd96;
	localparam logic [7:0] OUT_HEIGHT_RESET = 8'd64;

	// Register indexes, taken from paddr[2].
	localparam logic REG_OUT_WIDTH  = 1'b0;
	localparam logic REG_OUT_HEIGHT = 1'b1;

	// Input mode codes.
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_PIXEL   = 1'b1;

	typedef struct packed {
		logic [COLOR_W-1:0] colour;
		logic               eof;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

/* sv/palette_downscale_pixel_stream.sv */
// ----------------------------------------------------------------------------
// Palette downscaling pixel stream
// Nearest-neighbour downscaler with an RGB565 palette, byte-wide output.
// ----------------------------------------------------------------------------
// The input channel (pix_valid/pix_ready) carries palette writes (mode 0) and
// 8-bit indexed source pixels in raster order (mode 1); start_of_frame puts a
// pixel at column 0, row 0. The output channel (byte_valid/byte_ready) sends
// each kept pixel as a high byte then a low byte, with last_of_pixel on the
// low byte and end_of_frame on the low byte of the frame's last pixel.
// The user must write out_width and out_height over the APB port while idle;
// the block does not enforce this. One input transfer is taken per cycle
// while pix_ready is high. A kept pixel's high byte appears once the palette
// RAM read is registered and the colour is written into the queue. The byte
// side sends two bytes per kept pixel, so sustained input runs at one a cycle
// as long as at most one pixel in two is kept. If the receiver stalls, the
// four-entry colour queue fills and pix_ready falls until an entry drains.
// Reset clears the raster counters, empties the queue and sets the sizes to
// 96 by 64; the palette keeps its contents and needs writing before use.
// ----------------------------------------------------------------------------
module palette_downscale_pixel_stream import pds_pkg::*; #(
	parameter int SRC_WIDTH     = 320,
	parameter int SRC_HEIGHT    = 200,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic        mode,
	input  logic [7:0]  entry_number,
	input  logic [15:0] entry_color,
	input  logic [7:0]  pixel_code,
	input  logic        start_of_frame,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  data_byte,
	output logic        last_of_pixel,
	output logic        end_of_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [8:0]     out_width_q;
	logic [7:0]     out_height_q;
	push_t          push;
	entry_t         head;
	logic           not_empty, pop;
	logic [QCW-1:0] fifo_count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= OUT_WIDTH_RESET;
			out_height_q <= OUT_HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_OUT_WIDTH:  out_width_q  <= pwdata[8:0];
				REG_OUT_HEIGHT: out_height_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OUT_WIDTH:  prdata = 32'(out_width_q);
			REG_OUT_HEIGHT: prdata = 32'(out_height_q);
			default:        prdata = '0;
		endcase
	end

	pds_front #(
		.SRC_WIDTH    (SRC_WIDTH),
		.SRC_HEIGHT   (SRC_HEIGHT),
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.mode          (mode),
		.entry_number  (entry_number),
		.entry_color   (entry_color),
		.pixel_code    (pixel_code),
		.start_of_frame(start_of_frame),
		.out_width     (out_width_q),
		.out_height    (out_height_q),
		.fifo_count    (fifo_count),
		.push          (push)
	);

	pds_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.count    (fifo_count)
	);

	pds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.last_of_pixel(last_of_pixel),
		.end_of_frame (end_of_frame)
	);

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= QCW'(QUEUE_DEPTH))
		else $error("colour queue overflow");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count == QCW'(QUEUE_DEPTH)) |-> !pix_ready)
		else $error("input taken while the queue is full");

	a_low_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_ready && !last_of_pixel) |=> (byte_valid && last_of_pixel))
		else $error("high byte not followed by its low byte");

	a_write_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && (mode == MODE_PALETTE)) |=> !push.valid)
		else $error("palette write produced a queued colour");
`endif

endmodule

/* sv/pds_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/pds_front.sv */
// ----------------------------------------------------------------------------
// Palette downscale front
// Accepts palette writes and source pixels, tracks the raster, picks the
// kept pixels and looks their colour up in the palette.
// ----------------------------------------------------------------------------
module pds_front import pds_pkg::*; #(
	parameter int SRC_WIDTH     = 320,
	parameter int SRC_HEIGHT    = 200,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic               mode,
	input  logic [7:0]         entry_number,
	input  logic [15:0]        entry_color,
	input  logic [7:0]         pixel_code,
	input  logic               start_of_frame,
	input  logic [8:0]         out_width,
	input  logic [7:0]         out_height,
	input  logic [QCW-1:0]     fifo_count,
	output push_t              push
);

	localparam int SCW = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
	localparam int SRW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
	localparam int PW  = SCW + 9;
	localparam int RPW = SRW + 8;
	localparam int AW  = $clog2(PALETTE_DEPTH);

	localparam logic [SCW-1:0] SC_LAST  = SCW'(SRC_WIDTH - 1);
	localparam logic [SRW-1:0] SR_LAST  = SRW'(SRC_HEIGHT - 1);
	localparam logic [PW-1:0]  COL_STEP = PW'(SRC_WIDTH);
	localparam logic [RPW-1:0] ROW_STEP = RPW'(SRC_HEIGHT);

	logic [SCW-1:0] scol_q, scol_c, scol_n;
	logic [SRW-1:0] srow_q, srow_c, srow_n, srow_inc;
	logic [8:0]     ocol_q, ocol_c, ocol_n;
	logic [7:0]     orow_q, orow_c, orow_n, orow_inc;
	logic           rk_q, rk_c, rk_n;
	logic [PW-1:0]  cacc_q, cacc_c, cacc_n, col_base;
	logic [RPW-1:0] racc_q, racc_c, racc_n, racc_inc, row_base;
	logic [8:0]     w_eff;
	logic [7:0]     h_eff;
	logic           keep, eof, accept, pix_take;
	logic           wr_in_range, rd_in_range;
	logic           valid_s1, eof_s1, oor_s1;
	logic [COLOR_W-1:0] rdata;

	// Registers are used saturated; zero acts as one.
	always_comb begin
		if (out_width == 9'd0) begin
			w_eff = 9'd1;
		end else if (11'(out_width) > 11'(SRC_WIDTH)) begin
			w_eff = 9'(SRC_WIDTH);
		end else begin
			w_eff = out_width;
		end
		if (out_height == 8'd0) begin
			h_eff = 8'd1;
		end else if (11'(out_height) > 11'(SRC_HEIGHT)) begin
			h_eff = 8'(SRC_HEIGHT);
		end else begin
			h_eff = out_height;
		end
	end

	assign pix_ready = (4'(fifo_count) + 4'(valid_s1)) < 4'(QUEUE_DEPTH);
	assign accept    = pix_valid && pix_ready;
	assign pix_take  = accept && (mode == MODE_PIXEL);

	// A start of frame puts this very pixel at column 0, row 0.
	always_comb begin
		if (start_of_frame) begin
			scol_c = '0;
			srow_c = '0;
			ocol_c = '0;
			orow_c = '0;
			rk_c   = 1'b1;
			cacc_c = '0;
			racc_c = '0;
		end else begin
			scol_c = scol_q;
			srow_c = srow_q;
			ocol_c = ocol_q;
			orow_c = orow_q;
			rk_c   = rk_q;
			cacc_c = cacc_q;
			racc_c = racc_q;
		end
	end

	// The column is kept when scol*w <= ocol*SRC_WIDTH < (scol+1)*w, which is
	// the floor mapping without a divider. cacc holds ocol*SRC_WIDTH.
	assign col_base = PW'(scol_c) * PW'(w_eff);
	assign keep = rk_c && (ocol_c < w_eff) && (orow_c < h_eff) &&
		(cacc_c >= col_base) && (cacc_c < col_base + PW'(w_eff));
	assign eof = (ocol_c == w_eff - 9'd1) && (orow_c == h_eff - 8'd1);

	// Row selection for the next line, in the same form with racc = orow*SRC_HEIGHT.
	assign srow_inc = srow_c + SRW'(1);
	assign orow_inc = orow_c + 8'(rk_c);
	assign racc_inc = racc_c + (rk_c ? ROW_STEP : '0);
	assign row_base = RPW'(srow_inc) * RPW'(h_eff);

	always_comb begin
		scol_n = scol_c + SCW'(1);
		srow_n = srow_c;
		ocol_n = keep ? ocol_c + 9'd1 : ocol_c;
		orow_n = orow_c;
		rk_n   = rk_c;
		cacc_n = keep ? cacc_c + COL_STEP : cacc_c;
		racc_n = racc_c;
		if (scol_c == SC_LAST) begin
			scol_n = '0;
			ocol_n = '0;
			cacc_n = '0;
			if (srow_c == SR_LAST) begin
				srow_n = '0;
				orow_n = '0;
				rk_n   = 1'b1;
				racc_n = '0;
			end else begin
				srow_n = srow_inc;
				orow_n = orow_inc;
				racc_n = racc_inc;
				rk_n   = (orow_inc < h_eff) && (racc_inc >= row_base) &&
					(racc_inc < row_base + RPW'(h_eff));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q   <= '0;
			srow_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			rk_q     <= 1'b1;
			cacc_q   <= '0;
			racc_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pix_take && keep;
			if (pix_take) begin
				scol_q <= scol_n;
				srow_q <= srow_n;
				ocol_q <= ocol_n;
				orow_q <= orow_n;
				rk_q   <= rk_n;
				cacc_q <= cacc_n;
				racc_q <= racc_n;
			end
		end
	end

	assign wr_in_range = {1'b0, entry_number} < 9'(PALETTE_DEPTH);
	assign rd_in_range = {1'b0, pixel_code} < 9'(PALETTE_DEPTH);

	// A write accepted after a pixel lands after that pixel's read, so the
	// palette is seen in transfer order.
	pds_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (accept && (mode == MODE_PALETTE) && wr_in_range),
		.waddr(entry_number[AW-1:0]),
		.wdata(entry_color),
		.re   (pix_take && keep),
		.raddr(pixel_code[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (pix_take) begin
			eof_s1 <= eof;
			oor_s1 <= !rd_in_range;
		end
	end

	assign push.valid        = valid_s1;
	assign push.entry.colour = oor_s1 ? '0 : rdata;
	assign push.entry.eof    = eof_s1;

endmodule

/* sv/pds_fifo.sv */
// ----------------------------------------------------------------------------
// Palette downscale queue
// Short register queue of looked-up colours between the front and the back.
// ----------------------------------------------------------------------------
module pds_fifo import pds_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  push_t          push,
	input  logic           pop,
	output entry_t         head,
	output logic           not_empty,
	output logic [QCW-1:0] count
);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QCW-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push.valid) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

/* sv/pds_back.sv */
// ----------------------------------------------------------------------------
// Palette downscale back
// Sends each queued colour as a high byte and then a low byte.
// ----------------------------------------------------------------------------
module pds_back import pds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            head,
	input  logic              not_empty,
	output logic              pop,
	output logic              byte_valid,
	input  logic              byte_ready,
	output logic [BYTE_W-1:0] data_byte,
	output logic              last_of_pixel,
	output logic              end_of_frame
);

	logic low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			low_q <= !low_q;
		end
	end

	assign byte_valid    = not_empty;
	assign data_byte     = low_q ? head.colour[BYTE_W-1:0] : head.colour[COLOR_W-1:BYTE_W];
	assign last_of_pixel = low_q;
	assign end_of_frame  = low_q && head.eof;
	assign pop           = byte_valid && byte_ready && low_q;

endmodule
